// ----- rtl/upl_pkg.sv -----
// Shared definitions for the URL path locator: sizes, character codes and
// the one-hot recognizer phase type. No dependencies.
package upl_pkg;

  // Largest URL the buffer holds, in bytes.
  localparam int unsigned MaxUrlBytes = 4096;

  // Byte offsets run up to MaxUrlBytes, so one extra bit over the index.
  localparam int unsigned PosW = $clog2(MaxUrlBytes) + 1;

  // Output field widths and saturation limits.
  localparam int unsigned StartW   = 12;
  localparam int unsigned LengthW  = 13;
  localparam int unsigned StartMax = 4095;
  localparam int unsigned LenMax   = 8191;

  // Characters the recognizer looks for.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChQuery = 8'h3f;
  localparam logic [7:0] ChSlash = 8'h2f;

  // Result status codes.
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  // Recognizer phases, one-hot.
  typedef enum logic [6:0] {
    PhPathOrScheme = 7'b0000001,
    PhSchemeOrPort = 7'b0000010,
    PhPort         = 7'b0000100,
    PhFirstSlash   = 7'b0001000,
    PhSecondSlash  = 7'b0010000,
    PhServer       = 7'b0100000,
    PhPath         = 7'b1000000
  } phase_e;

  // One result word as the parser hands it to the output register.
  typedef struct packed {
    logic               valid;
    logic               status;
    logic [StartW-1:0]  path_start;
    logic [LengthW-1:0] path_length;
  } result_t;

  // True in the phases where the bytes seen so far may be a path.
  function automatic logic in_path(input phase_e ph);
    return (ph == PhPath) || (ph == PhPathOrScheme);
  endfunction

endpackage

// ----- rtl/url_path_locator.sv -----
// Top level of the URL path locator: input register, recognizer and
// output register. Depends on upl_pkg and upl_parser.

// The block takes one URL byte per word and gives one result word per URL
// holding status, path start offset and path length. Each accepted byte is
// held in an input register, and the recognizer step between that register
// and the output register decides the next phase and any result. While the
// result side keeps up, a byte is accepted in every cycle, and the result for
// the URL's last byte is registered as it leaves the input register. While a
// result waits to be taken, the byte behind it stays in the input register
// and no further byte is accepted until the result is taken. Bytes after a
// result are dropped until first_byte_i marks a new URL.
module url_path_locator
  import upl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          char_in_i,
  input  logic                first_byte_i,
  input  logic                buffer_end_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                status_o,
  output logic [StartW-1:0]   path_start_o,
  output logic [LengthW-1:0]  path_length_o
);

  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        first_q;
  logic        bend_q;
  logic        advance;
  result_t     result;
  logic        out_valid_q;
  logic        status_q;
  logic [StartW-1:0]  start_q;
  logic [LengthW-1:0] length_q;

  // The held byte moves on when the output register is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q  <= char_in_i;
      first_q <= first_byte_i;
      bend_q  <= buffer_end_i;
    end
  end

  upl_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .char_in_i    (char_q),
    .first_byte_i (first_q),
    .buffer_end_i (bend_q),
    .result_o     (result)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      status_q <= result.status;
      start_q  <= result.path_start;
      length_q <= result.path_length;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign path_start_o  = start_q;
  assign path_length_o = length_q;

endmodule

// ----- rtl/upl_parser.sv -----
// Recognizer state and per-byte step logic of the URL path locator.
// Depends on upl_pkg.
module upl_parser
  import upl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_in_i,
  input  logic       first_byte_i,
  input  logic       buffer_end_i,
  output result_t    result_o
);

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   start_q, start_d;
  logic              fin_q, fin_d;

  phase_e            ph;
  logic [PosW-1:0]   pos;
  logic [PosW-1:0]   start;
  logic              fin;
  logic              emit;
  logic              bad;
  logic              early;
  logic              fail;
  logic              last;
  logic [PosW-1:0]   end_pos;
  logic [PosW-1:0]   len;

  // A first byte restarts the recognizer before the byte is handled.
  assign ph    = first_byte_i ? PhPathOrScheme : phase_q;
  assign pos   = first_byte_i ? '0 : pos_q;
  assign start = first_byte_i ? '0 : start_q;
  assign fin   = first_byte_i ? 1'b0 : fin_q;

  assign last = buffer_end_i || (32'(pos) >= (MaxUrlBytes - 1));

  // Step the recognizer by one byte.
  always_comb begin
    phase_d = ph;
    pos_d   = pos;
    start_d = start;
    fin_d   = fin;
    emit    = 1'b0;
    bad     = 1'b0;
    early   = 1'b0;
    fail    = 1'b0;
    end_pos = pos;
    if (!fin) begin
      if (char_in_i == ChNul) begin
        emit = 1'b1;
        bad  = !in_path(ph);
      end else begin
        unique case (ph)
          PhPathOrScheme: begin
            if (char_in_i == ChColon) begin
              phase_d = PhSchemeOrPort;
            end else if (char_in_i == ChHash || char_in_i == ChQuery) begin
              early = 1'b1;
            end
          end
          PhSchemeOrPort: begin
            phase_d = (char_in_i == ChSlash) ? PhFirstSlash : PhPort;
          end
          PhPort: begin
            if (char_in_i == ChSlash) begin
              phase_d = PhPath;
              start_d = pos + PosW'(1);
            end
          end
          PhFirstSlash: begin
            if (char_in_i != ChSlash) begin
              fail = 1'b1;
            end else begin
              phase_d = PhSecondSlash;
            end
          end
          PhSecondSlash: begin
            phase_d = PhServer;
          end
          PhServer: begin
            if (char_in_i == ChSlash) begin
              phase_d = PhPath;
              start_d = pos;
            end
          end
          PhPath: begin
            if (char_in_i == ChHash || char_in_i == ChQuery) begin
              early = 1'b1;
            end
          end
          default: begin
            phase_d = PhPathOrScheme;
          end
        endcase

        priority if (early) begin
          emit = 1'b1;
        end else if (fail) begin
          emit = 1'b1;
          bad  = 1'b1;
        end else if (last) begin
          emit    = 1'b1;
          bad     = !in_path(phase_d);
          end_pos = pos + PosW'(1);
        end else begin
          pos_d = pos + PosW'(1);
        end
      end
    end
    if (emit) begin
      fin_d = 1'b1;
    end
  end

  // Path length, never negative.
  assign len = (end_pos >= start_d) ? (end_pos - start_d) : '0;

  // Result word with saturation of the output fields.
  always_comb begin
    result_o.valid = emit;
    if (bad) begin
      result_o.status      = StatusBad;
      result_o.path_start  = '0;
      result_o.path_length = '0;
    end else begin
      result_o.status      = StatusOk;
      result_o.path_start  = (32'(start_d) > StartMax) ? StartW'(StartMax)
                                                       : StartW'(start_d);
      result_o.path_length = (32'(len) > LenMax) ? LengthW'(LenMax)
                                                 : LengthW'(len);
    end
  end

  // Recognizer state advances once per handled byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPathOrScheme;
      pos_q   <= '0;
      start_q <= '0;
      fin_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// ----- test/upl_path_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the URL path locator: it watches both channels, predicts
// each result word from the accepted bytes and compares it field by field.
// Depends on upl_pkg.
module upl_path_checker
  import upl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         char_in_i,
  input  logic               first_byte_i,
  input  logic               buffer_end_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               status_i,
  input  logic [StartW-1:0]  path_start_i,
  input  logic [LengthW-1:0] path_length_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);

  // One located path as the block should report it.
  typedef struct packed {
    logic               status;
    logic [StartW-1:0]  start;
    logic [LengthW-1:0] length;
  } path_span_t;

  // Predicted recognizer state. Offsets are kept wide so that a start just
  // past the buffer is seen before it saturates.
  phase_e      phase_q;
  int unsigned next_pos_q;
  int unsigned path_from_q;
  logic        url_done_q;

  path_span_t  expected_spans[$];
  path_span_t  seen_span;
  path_span_t  want_span;
  int unsigned failures;

  function automatic logic may_be_path(input phase_e ph);
    return (ph == PhPath) || (ph == PhPathOrScheme);
  endfunction

  // Advances the predicted recognizer by one byte and queues the result
  // that byte causes, if any.
  task automatic locate_path(input logic [7:0] ch, input logic restart, input logic at_end);
    int unsigned pos;
    int unsigned path_end;
    int unsigned len;
    logic        last;
    logic        found;
    logic        bad;
    path_span_t  span;
    if (restart) begin
      phase_q     = PhPathOrScheme;
      next_pos_q  = 0;
      path_from_q = 0;
      url_done_q  = 1'b0;
    end
    if (url_done_q) return;

    pos      = next_pos_q;
    last     = at_end || (pos >= MaxUrlBytes - 1);
    found    = 1'b0;
    bad      = 1'b0;
    path_end = pos;

    if (ch == ChNul) begin
      // A terminator ends the URL; it is fine only where a path may be open.
      found = 1'b1;
      bad   = !may_be_path(phase_q);
    end else begin
      case (phase_q)
        PhPathOrScheme: begin
          if (ch == ChColon) phase_q = PhSchemeOrPort;
          else if (ch == ChHash || ch == ChQuery) found = 1'b1;
        end
        PhSchemeOrPort: begin
          phase_q = (ch == ChSlash) ? PhFirstSlash : PhPort;
        end
        PhPort: begin
          // The path begins just past the slash that ends the port.
          if (ch == ChSlash) begin
            phase_q     = PhPath;
            path_from_q = pos + 1;
          end
        end
        PhFirstSlash: begin
          if (ch != ChSlash) begin
            found = 1'b1;
            bad   = 1'b1;
          end else begin
            phase_q = PhSecondSlash;
          end
        end
        PhSecondSlash: begin
          phase_q = PhServer;
        end
        PhServer: begin
          // The slash after the server is the first byte of the path.
          if (ch == ChSlash) begin
            phase_q     = PhPath;
            path_from_q = pos;
          end
        end
        PhPath: begin
          if (ch == ChHash || ch == ChQuery) found = 1'b1;
        end
        default: begin
          phase_q = PhPathOrScheme;
        end
      endcase
      // The last byte the buffer allows closes the URL, byte included.
      if (!found && last) begin
        found    = 1'b1;
        bad      = !may_be_path(phase_q);
        path_end = pos + 1;
      end
    end

    if (!found) begin
      next_pos_q = pos + 1;
      return;
    end

    url_done_q = 1'b1;
    len = (path_end >= path_from_q) ? path_end - path_from_q : 0;
    span.status = bad ? StatusBad : StatusOk;
    span.start  = bad ? '0 : StartW'((path_from_q > StartMax) ? StartMax : path_from_q);
    span.length = bad ? '0 : LengthW'((len > LenMax) ? LenMax : len);
    expected_spans.push_back(span);
  endtask

  // Results are checked before the byte of the same edge is predicted; a
  // result can never belong to a byte accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      = PhPathOrScheme;
      next_pos_q   = 0;
      path_from_q  = 0;
      url_done_q   = 1'b0;
      failures     = 0;
      expected_spans.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen_span = '{status_i, path_start_i, path_length_i};
        if (expected_spans.size() == 0) begin
          $error("result word with none expected: status %0d, path_start %0d, path_length %0d",
                 status_i, path_start_i, path_length_i);
          failures++;
        end else begin
          want_span = expected_spans.pop_front();
          if (seen_span.status !== want_span.status) begin
            $error("status: expected %0d, got %0d", want_span.status, seen_span.status);
            failures++;
          end
          if (seen_span.start !== want_span.start) begin
            $error("path_start: expected %0d, got %0d", want_span.start, seen_span.start);
            failures++;
          end
          if (seen_span.length !== want_span.length) begin
            $error("path_length: expected %0d, got %0d", want_span.length, seen_span.length);
            failures++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        locate_path(char_in_i, first_byte_i, buffer_end_i);
      end
      pending_o    <= expected_spans.size();
      fail_count_o <= failures;
    end
  end

endmodule

// ----- test/url_path_locator_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the URL path locator: clock, reset, byte stimulus, result
// back-pressure and the verdict. Depends on upl_pkg, url_path_locator and
// upl_path_checker.
module url_path_locator_tb;
  import upl_pkg::*;

  localparam int unsigned RandomBytes = 620;
  localparam int unsigned IdleLimit   = 1000;

  // How the result side takes words during one stretch.
  typedef enum int unsigned {
    TakeAlways,
    TakeHalf,
    TakeMostly,
    TakeNone
  } take_mode_e;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic [7:0]         char_in     = '0;
  logic               first_byte  = 1'b0;
  logic               buffer_end  = 1'b0;
  logic               out_ready   = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic               status;
  logic [StartW-1:0]  path_start;
  logic [LengthW-1:0] path_length;

  int unsigned pending;
  int unsigned fail_count;

  // Bytes of the URL about to be sent.
  logic [7:0]  url_q[$];

  int unsigned burst_left     = 0;
  int unsigned bytes_sent     = 0;
  int unsigned urls_sent      = 0;
  int unsigned paths_found    = 0;
  int unsigned urls_malformed = 0;
  int unsigned idle_cycles    = 0;
  int unsigned take_run       = 0;
  take_mode_e  take_mode      = TakeAlways;

  always #2 clk = ~clk;

  url_path_locator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .char_in_i     (char_in),
    .first_byte_i  (first_byte),
    .buffer_end_i  (buffer_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .path_start_o  (path_start),
    .path_length_o (path_length)
  );

  upl_path_checker path_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .char_in_i     (char_in),
    .first_byte_i  (first_byte),
    .buffer_end_i  (buffer_end),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .path_start_i  (path_start),
    .path_length_i (path_length),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // The result side switches between stretches of steady taking, random
  // taking and full stalls.
  always @(posedge clk) begin
    if (take_run == 0) begin
      take_mode <= take_mode_e'($urandom_range(0, 3));
      take_run  <= $urandom_range(4, 40);
    end else begin
      take_run <= take_run - 1;
    end
    case (take_mode)
      TakeAlways: out_ready <= 1'b1;
      TakeHalf:   out_ready <= 1'($urandom_range(0, 1));
      TakeMostly: out_ready <= ($urandom_range(0, 3) != 0);
      default:    out_ready <= 1'b0;
    endcase
  end

  // Watchdog on cycles where no word moves, and result tallies.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
        $error("no word moved for %0d cycles", IdleLimit);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        if (status == StatusOk) paths_found <= paths_found + 1;
        else urls_malformed <= urls_malformed + 1;
      end
    end
  end

  // Sends one byte; the sender may idle between bursts of random length.
  task automatic send_byte(input logic [7:0] ch, input logic restart, input logic at_end);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    char_in    <= ch;
    first_byte <= restart;
    buffer_end <= at_end;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Sends the queued URL; end_at marks the byte flagged as the buffer's
  // last one, or none when negative.
  task automatic send_url(input logic mark_first, input int end_at);
    for (int i = 0; i < url_q.size(); i++) begin
      send_byte(url_q[i], mark_first && (i == 0), i == end_at);
    end
    urls_sent++;
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Any byte the recognizer treats as plain text.
  function automatic logic [7:0] text_byte();
    logic [7:0] ch;
    do begin
      ch = 8'($urandom_range(1, 255));
    end while (ch == ChColon || ch == ChSlash || ch == ChHash || ch == ChQuery);
    return ch;
  endfunction

  task automatic add_text(input int unsigned count, input logic with_slashes);
    repeat (count) begin
      if (with_slashes && $urandom_range(0, 5) == 0) url_q.push_back(ChSlash);
      else url_q.push_back(text_byte());
    end
  endtask

  // Builds a random URL: mostly well-formed shapes with random text, some
  // with a byte dropped, some pure noise, and a random way of ending.
  task automatic make_url(output int end_at);
    int unsigned shape;
    int unsigned ending;
    url_q.delete();
    end_at = -1;
    shape  = $urandom_range(0, 9);
    if (shape <= 2) begin
      add_text($urandom_range(0, 10), 1'b1);
    end else if (shape <= 5) begin
      add_text($urandom_range(1, 5), 1'b0);
      url_q.push_back(ChColon);
      url_q.push_back(ChSlash);
      url_q.push_back(ChSlash);
      add_text($urandom_range(1, 6), 1'b0);
      url_q.push_back(ChSlash);
      add_text($urandom_range(0, 10), 1'b1);
    end else if (shape <= 8) begin
      add_text($urandom_range(1, 6), 1'b0);
      url_q.push_back(ChColon);
      add_text($urandom_range(1, 4), 1'b0);
      url_q.push_back(ChSlash);
      add_text($urandom_range(0, 10), 1'b1);
    end else begin
      repeat ($urandom_range(1, 12)) url_q.push_back(8'($urandom_range(0, 255)));
    end
    if (shape <= 8 && url_q.size() != 0 && $urandom_range(0, 7) == 0) begin
      url_q.delete($urandom_range(0, url_q.size() - 1));
    end

    ending = $urandom_range(0, 9);
    case (ending)
      0, 1, 2, 3: url_q.push_back(ChNul);
      4:          url_q.push_back(ChHash);
      5:          url_q.push_back(ChQuery);
      6: begin
        if (url_q.size() == 0) url_q.push_back(text_byte());
        end_at = url_q.size() - 1;
      end
      7: begin
        // No ending at all: the next URL restarts the recognizer.
      end
      default: begin
        url_q.push_back(ChNul);
        repeat ($urandom_range(1, 3)) url_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    if (url_q.size() == 0) url_q.push_back(ChNul);
  endtask

  initial begin : stimulus
    int          end_at;
    int unsigned random_from;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Without a new-URL marker after reset the first byte still opens a URL;
    // the '#' gives an empty path and the byte after it is ignored.
    url_q = '{ChHash, 8'hff};
    send_url(1'b0, -1);
    // Single slash after the scheme, then a wrong byte.
    url_q = '{ChColon, ChSlash, "x"};
    send_url(1'b1, -1);
    // Terminator in the scheme, port and server phases.
    url_q = '{"h", ChColon, ChNul};
    send_url(1'b1, -1);
    url_q = '{"h", ChColon, "8", ChNul};
    send_url(1'b1, -1);
    url_q = '{ChColon, ChSlash, ChSlash, "s", ChNul};
    send_url(1'b1, -1);
    // Port slash as the last byte: an empty path just past the buffer.
    url_q = '{"h", ChColon, "9", ChSlash};
    send_url(1'b1, 3);
    // One-byte bare path cut by the buffer end.
    url_q = '{8'hff};
    send_url(1'b1, 0);
    // Buffer ends before the path has begun.
    url_q = '{ChColon};
    send_url(1'b1, 0);
    // Empty URL.
    url_q = '{ChNul};
    send_url(1'b1, -1);
    // Server form with the path cut short by a query.
    url_q = '{ChColon, ChSlash, ChSlash, "s", ChSlash, "p", ChQuery};
    send_url(1'b1, -1);
    settle();

    // Random URLs, with an occasional pause until all results are back.
    random_from = bytes_sent;
    while (bytes_sent - random_from < RandomBytes) begin
      make_url(end_at);
      send_url($urandom_range(0, 15) != 0, end_at);
      if ($urandom_range(0, 24) == 0) settle();
    end

    // Wait for the last results and give stray words time to show up.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d URLs: directed corner cases and random shapes.",
             bytes_sent, urls_sent);
    $display("Results taken: %0d paths located, %0d malformed URLs.",
             paths_found, urls_malformed);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/upl_pkg.sv
rtl/upl_parser.sv
rtl/url_path_locator.sv
test/upl_path_checker.sv
test/url_path_locator_tb.sv
